// ----- design/snjs_pkg.sv -----
// snjs_pkg: shared types, token codes and constants for the SPI NOR job sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none
package snjs_pkg;

	localparam int READ_CHUNK = 1024;

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_PDATA = 2'd1;
	localparam logic [1:0] REQ_RDATA = 2'd2;
	localparam logic [1:0] REQ_ADV   = 2'd3;

	localparam logic [1:0] JOB_READ  = 2'd0;
	localparam logic [1:0] JOB_PROG  = 2'd1;
	localparam logic [1:0] JOB_ERASE = 2'd2;

	localparam logic [2:0] TK_BYTE  = 3'd0;
	localparam logic [2:0] TK_CS    = 3'd1;
	localparam logic [2:0] TK_WAIT  = 3'd2;
	localparam logic [2:0] TK_QUAD  = 3'd3;
	localparam logic [2:0] TK_RREQ  = 3'd4;
	localparam logic [2:0] TK_RDATA = 3'd5;
	localparam logic [2:0] TK_DONE  = 3'd6;
	localparam logic [2:0] TK_REJ   = 3'd7;

	localparam logic [1:0] CFG_SECTOR = 2'd0;
	localparam logic [1:0] CFG_PAGE   = 2'd1;
	localparam logic [1:0] CFG_WIDE   = 2'd2;

	localparam logic [7:0] OP_WREN  = 8'h06;
	localparam logic [7:0] OP_RDSR  = 8'h05;
	localparam logic [7:0] OP_CLSR  = 8'h30;
	localparam logic [7:0] OP_WRR   = 8'h01;
	localparam logic [7:0] OP_SRVAL = 8'h02;
	localparam logic [7:0] OP_SE    = 8'hD8;
	localparam logic [7:0] OP_QPP3  = 8'h32;
	localparam logic [7:0] OP_QPP4  = 8'h34;
	localparam logic [7:0] OP_QRD3  = 8'h6b;
	localparam logic [7:0] OP_QRD4  = 8'h6c;
	localparam logic [7:0] OP_DUMMY = 8'hdd;

	// one item's worth of work, segments go out in bit order
	typedef struct packed {
		logic        rej;
		logic        lead;
		logic        lead_rdata;
		logic [7:0]  val;
		logic        preamb;
		logic        trail;
		logic        erase;
		logic        hdr;
		logic        rcmd;
		logic        done;
		logic        wide;
		logic [31:0] addr;
		logic [10:0] count;
	} desc_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [10:0] value;
		logic        last;
	} tok_t;

endpackage
`default_nettype wire

// ----- design/spi_nor_job_sequencer.sv -----
// spi_nor_job_sequencer: top level; front, descriptor queue and token back end.
// Depends on snjs_pkg, snjs_front, snjs_dq and snjs_back.
//
//   channel   handshake         payload
//   input     push / full       req_type job_kind start_address byte_count data_byte
//   result    empty / pop       token_kind token_value last
//   config    cfg_write         cfg_index cfg_data
//
// The front takes one item a cycle while the descriptor queue has room.
// The back sends one token a cycle while the result queue has room; an item holds
// it until all its tokens are out, so the token count per item sets the sustained rate.
// Reset clears job state and loads register defaults; no clearing pass.
// A full result queue stalls the back, a full descriptor queue raises full.
`default_nettype none
module spi_nor_job_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [4:0]  cfg_data,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  req_type,
	input  wire logic [1:0]  job_kind,
	input  wire logic [31:0] start_address,
	input  wire logic [31:0] byte_count,
	input  wire logic [7:0]  data_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       token_kind,
	output logic [10:0]      token_value,
	output logic             last
);
	import snjs_pkg::*;

	logic  take, dpush, dvalid, dpop;
	desc_t wd, rd;

	assign take = push && !full;

	snjs_front u_front (
		.clk, .arst_n, .cfg_write, .cfg_index, .cfg_data, .take,
		.req_type, .job_kind, .start_address, .byte_count, .data_byte,
		.dpush, .ddata(wd)
	);

	snjs_dq u_dq (
		.clk, .arst_n, .push(dpush), .wdata(wd), .full,
		.valid(dvalid), .rdata(rd), .pop(dpop)
	);

	snjs_back u_back (
		.clk, .arst_n, .dvalid, .ddata(rd), .dpop,
		.empty, .pop, .token_kind, .token_value, .last
	);

	a_rej_alone: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && token_kind == TK_REJ |-> last) else $error("rejected token not last");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && token_kind == TK_DONE |-> last) else $error("done token not last");
	a_rreq_len: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && token_kind == TK_RREQ |-> token_value != '0 && token_value <= 11'd1024)
		else $error("bad read request length");

endmodule
`default_nettype wire

// ----- design/snjs_front.sv -----
// snjs_front: accepts items, keeps job state and the configuration registers,
// and turns each item into a work descriptor. Depends on snjs_pkg.
`default_nettype none
module snjs_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [4:0]         cfg_data,
	input  wire logic               take,
	input  wire logic [1:0]         req_type,
	input  wire logic [1:0]         job_kind,
	input  wire logic [31:0]        start_address,
	input  wire logic [31:0]        byte_count,
	input  wire logic [7:0]         data_byte,
	output logic                    dpush,
	output snjs_pkg::desc_t         ddata
);
	import snjs_pkg::*;

	typedef enum logic [1:0] {PH_IDLE, PH_READ, PH_PROG, PH_ERASE} phase_t;

	phase_t      phase_q, phase_n;
	logic [31:0] cur_q, cur_n, rem_q, rem_n;
	logic [12:0] pb_q, pb_n;
	logic [10:0] cl_q, cl_n;
	logic [4:0]  sect_cfg_q;
	logic [3:0]  page_cfg_q;
	logic        wide_q;

	logic [4:0]  sl;
	logic [3:0]  pl;
	logic [31:0] smask;
	logic [31:0] off;
	logic [32:0] tot;
	logic [31:0] nsect;
	logic [31:0] cur_dec, rem_dec;
	logic [12:0] pb_dec;
	logic [10:0] cl_dec;
	desc_t       d;

	function automatic logic [12:0] page_fill(input logic [3:0] l, input logic [31:0] a,
			input logic [31:0] r);
		logic [12:0] pg;
		logic [12:0] b;
		pg = 13'd1 << l;
		b = pg - (a[12:0] & (pg - 13'd1));
		if ({19'd0, b} > r)
			b = r[12:0];
		return b;
	endfunction

	function automatic logic [10:0] chunk(input logic [31:0] r);
		return (r < 32'(READ_CHUNK)) ? r[10:0] : 11'(READ_CHUNK);
	endfunction

	always_comb begin
		sl = (sect_cfg_q < 5'd8) ? 5'd8 : ((sect_cfg_q > 5'd24) ? 5'd24 : sect_cfg_q);
		pl = (page_cfg_q > 4'd12) ? 4'd12 : page_cfg_q;
		smask = (32'd1 << sl) - 32'd1;
		off = start_address & smask;
		tot = {1'b0, off} + {1'b0, byte_count};
		nsect = 32'(tot >> sl) + {31'd0, |(tot[31:0] & smask)};
		cur_dec = cur_q + 32'd1;
		rem_dec = rem_q - 32'd1;
		pb_dec = pb_q - 13'd1;
		cl_dec = cl_q - 11'd1;
	end

	always_comb begin
		phase_n = phase_q;
		cur_n = cur_q;
		rem_n = rem_q;
		pb_n = pb_q;
		cl_n = cl_q;
		d = '0;
		d.wide = wide_q;
		dpush = take;
		unique case (req_type)
			REQ_START: begin
				if (phase_q != PH_IDLE || job_kind == 2'd3) begin
					d.rej = 1'b1;
				end else begin
					cur_n = start_address;
					rem_n = byte_count;
					pb_n = '0;
					cl_n = '0;
					if (job_kind == JOB_READ) begin
						if (byte_count == '0) begin
							d.done = 1'b1;
						end else begin
							phase_n = PH_READ;
							d.rcmd = 1'b1;
							d.addr = start_address;
							d.count = chunk(byte_count);
							cl_n = chunk(byte_count);
						end
					end else if (job_kind == JOB_PROG) begin
						d.preamb = 1'b1;
						if (byte_count == '0) begin
							d.done = 1'b1;
						end else begin
							phase_n = PH_PROG;
							d.hdr = 1'b1;
							d.addr = start_address;
							pb_n = page_fill(pl, start_address, byte_count);
						end
					end else begin
						if (byte_count == '0) begin
							d.done = 1'b1;
						end else begin
							d.erase = 1'b1;
							d.addr = start_address - off;
							cur_n = start_address - off + (smask + 32'd1);
							rem_n = nsect - 32'd1;
							if (nsect == 32'd1)
								d.done = 1'b1;
							else
								phase_n = PH_ERASE;
						end
					end
				end
			end
			REQ_PDATA: begin
				if (phase_q != PH_PROG || pb_q == '0 || rem_q == '0) begin
					d.rej = 1'b1;
				end else begin
					d.lead = 1'b1;
					d.val = data_byte;
					cur_n = cur_dec;
					rem_n = rem_dec;
					pb_n = pb_dec;
					if (pb_dec == '0) begin
						d.trail = 1'b1;
						if (rem_dec == '0) begin
							d.done = 1'b1;
							phase_n = PH_IDLE;
						end else begin
							d.hdr = 1'b1;
							d.addr = cur_dec;
							pb_n = page_fill(pl, cur_dec, rem_dec);
						end
					end
				end
			end
			REQ_RDATA: begin
				if (phase_q != PH_READ || cl_q == '0 || rem_q == '0) begin
					d.rej = 1'b1;
				end else begin
					d.lead = 1'b1;
					d.lead_rdata = 1'b1;
					d.val = data_byte;
					cur_n = cur_dec;
					rem_n = rem_dec;
					cl_n = cl_dec;
					if (cl_dec == '0) begin
						if (rem_dec == '0) begin
							d.done = 1'b1;
							phase_n = PH_IDLE;
						end else begin
							d.rcmd = 1'b1;
							d.addr = cur_dec;
							d.count = chunk(rem_dec);
							cl_n = chunk(rem_dec);
						end
					end
				end
			end
			REQ_ADV: begin
				if (phase_q == PH_ERASE && rem_q != '0) begin
					d.erase = 1'b1;
					d.addr = cur_q;
					cur_n = cur_q + (smask + 32'd1);
					rem_n = rem_dec;
					if (rem_dec == '0) begin
						d.done = 1'b1;
						phase_n = PH_IDLE;
					end
				end else begin
					dpush = 1'b0;
				end
			end
			default: dpush = 1'b0;
		endcase
	end

	assign ddata = d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cur_q <= '0;
			rem_q <= '0;
			pb_q <= '0;
			cl_q <= '0;
			sect_cfg_q <= 5'd16;
			page_cfg_q <= 4'd8;
			wide_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_n;
				cur_q <= cur_n;
				rem_q <= rem_n;
				pb_q <= pb_n;
				cl_q <= cl_n;
			end
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_SECTOR: sect_cfg_q <= cfg_data;
					CFG_PAGE:   page_cfg_q <= cfg_data[3:0];
					CFG_WIDE:   wide_q <= cfg_data[0];
					default:    ;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/snjs_dq.sv -----
// snjs_dq: two-entry queue of work descriptors between front and back.
// Depends on snjs_pkg.
`default_nettype none
module snjs_dq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire snjs_pkg::desc_t    wdata,
	output logic                    full,
	output logic                    valid,
	output snjs_pkg::desc_t         rdata,
	input  wire logic               pop
);
	import snjs_pkg::*;

	desc_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

// ----- design/snjs_back.sv -----
// snjs_back: expands work descriptors into SPI NOR tokens, one a cycle while there
// is room, into a two-entry result queue. Depends on snjs_pkg.
`default_nettype none
module snjs_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               dvalid,
	input  wire snjs_pkg::desc_t    ddata,
	output logic                    dpop,
	output logic                    empty,
	input  wire logic               pop,
	output logic [2:0]              token_kind,
	output logic [10:0]             token_value,
	output logic                    last
);
	import snjs_pkg::*;

	typedef enum logic [2:0] {SG_REJ, SG_LEAD, SG_PREAMB, SG_TRAIL, SG_ERASE, SG_HDR,
		SG_RCMD, SG_DONE} seg_t;

	desc_t      d_q;
	logic [7:0] mask_q;
	logic [3:0] pos_q;
	tok_t       oq_q [2];
	logic       owp_q, orp_q;
	logic [1:0] ocnt_q;

	seg_t       seg;
	logic [7:0] low;
	logic [3:0] seg_len;
	logic [2:0] na;
	logic       busy, room, emit, seg_end, fin;
	tok_t       tok;

	function automatic logic [7:0] abyte(input logic [31:0] a, input logic w,
			input logic [1:0] k);
		logic [1:0] i;
		i = w ? k : k + 2'd1;
		unique case (i)
			2'd0:    return a[31:24];
			2'd1:    return a[23:16];
			2'd2:    return a[15:8];
			default: return a[7:0];
		endcase
	endfunction

	function automatic tok_t tb(input logic [7:0] v);
		return '{kind: TK_BYTE, value: {3'd0, v}, last: 1'b0};
	endfunction

	function automatic tok_t tk(input logic [2:0] k);
		return '{kind: k, value: '0, last: 1'b0};
	endfunction

	assign busy = |mask_q;
	assign low = mask_q & (~mask_q + 8'd1);
	assign na = d_q.wide ? 3'd4 : 3'd3;

	always_comb begin
		priority if (mask_q[0]) seg = SG_REJ;
		else if (mask_q[1]) seg = SG_LEAD;
		else if (mask_q[2]) seg = SG_PREAMB;
		else if (mask_q[3]) seg = SG_TRAIL;
		else if (mask_q[4]) seg = SG_ERASE;
		else if (mask_q[5]) seg = SG_HDR;
		else if (mask_q[6]) seg = SG_RCMD;
		else seg = SG_DONE;
	end

	always_comb begin
		tok = tk(TK_CS);
		seg_len = 4'd1;
		unique case (seg)
			SG_REJ:  tok = tk(TK_REJ);
			SG_DONE: tok = tk(TK_DONE);
			SG_LEAD: tok = '{kind: d_q.lead_rdata ? TK_RDATA : TK_BYTE,
				value: {3'd0, d_q.val}, last: 1'b0};
			SG_PREAMB: begin
				seg_len = 4'd11;
				unique case (pos_q)
					4'd0:    tok = tb(OP_WREN);
					4'd2:    tok = tb(OP_WRR);
					4'd3:    tok = tb(OP_SRVAL);
					4'd4:    tok = tb(OP_SRVAL);
					4'd6:    tok = tb(OP_RDSR);
					4'd7:    tok = tk(TK_WAIT);
					4'd9:    tok = tb(OP_WREN);
					default: tok = tk(TK_CS);
				endcase
			end
			SG_TRAIL: begin
				seg_len = 4'd6;
				unique case (pos_q)
					4'd1:    tok = tb(OP_RDSR);
					4'd2:    tok = tk(TK_WAIT);
					4'd4:    tok = tb(OP_WREN);
					default: tok = tk(TK_CS);
				endcase
			end
			SG_ERASE: begin
				seg_len = 4'd13;
				unique case (pos_q)
					4'd1:    tok = tb(OP_WREN);
					4'd3:    tok = tb(OP_CLSR);
					4'd5:    tok = tb(OP_SE);
					4'd6:    tok = tb(d_q.addr[23:16]);
					4'd7:    tok = tb(d_q.addr[15:8]);
					4'd8:    tok = tb(d_q.addr[7:0]);
					4'd10:   tok = tb(OP_RDSR);
					4'd11:   tok = tk(TK_WAIT);
					default: tok = tk(TK_CS);
				endcase
			end
			SG_HDR: begin
				seg_len = 4'd4 + {1'b0, na};
				if (pos_q == 4'd0)
					tok = tb(OP_WREN);
				else if (pos_q == 4'd1)
					tok = tk(TK_CS);
				else if (pos_q == 4'd2)
					tok = tb(d_q.wide ? OP_QPP4 : OP_QPP3);
				else if (pos_q == 4'd3 + {1'b0, na})
					tok = tk(TK_QUAD);
				else
					tok = tb(abyte(d_q.addr, d_q.wide, 2'(pos_q - 4'd3)));
			end
			SG_RCMD: begin
				seg_len = 4'd3 + {1'b0, na};
				if (pos_q == 4'd0)
					tok = tb(d_q.wide ? OP_QRD4 : OP_QRD3);
				else if (pos_q == {1'b0, na} + 4'd1)
					tok = tb(OP_DUMMY);
				else if (pos_q == {1'b0, na} + 4'd2)
					tok = '{kind: TK_RREQ, value: d_q.count, last: 1'b0};
				else
					tok = tb(abyte(d_q.addr, d_q.wide, 2'(pos_q - 4'd1)));
			end
			default: tok = tk(TK_CS);
		endcase
		tok.last = fin;
	end

	assign room = ocnt_q != 2'd2;
	assign emit = busy && room;
	assign seg_end = pos_q == seg_len - 4'd1;
	assign fin = seg_end && ((mask_q & ~low) == '0);
	assign dpop = dvalid && (!busy || (emit && fin));

	always_ff @(posedge clk) begin
		if (dpop)
			d_q <= ddata;
		if (emit)
			oq_q[owp_q] <= tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			pos_q <= '0;
			owp_q <= 1'b0;
			orp_q <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (dpop) begin
				mask_q <= {ddata.done, ddata.rcmd, ddata.hdr, ddata.erase, ddata.trail,
					ddata.preamb, ddata.lead, ddata.rej};
				pos_q <= '0;
			end else if (emit) begin
				if (seg_end) begin
					mask_q <= mask_q & ~low;
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 4'd1;
				end
			end
			if (emit)
				owp_q <= ~owp_q;
			if (pop && !empty)
				orp_q <= ~orp_q;
			ocnt_q <= ocnt_q + {1'b0, emit} - {1'b0, pop && !empty};
		end
	end

	assign empty = ocnt_q == 2'd0;
	assign token_kind = oq_q[orp_q].kind;
	assign token_value = oq_q[orp_q].value;
	assign last = oq_q[orp_q].last;

endmodule
`default_nettype wire
